/* src/uartrf_pkg.sv */
// Shared types and constants for the UART register file with receive FIFO.
`timescale 1ns / 1ps
`default_nettype none

package uartrf_pkg;

	// Receive FIFO geometry
	localparam int RX_DEPTH   = 16;
	localparam int FIFO_PTR_W = $clog2(RX_DEPTH);
	localparam int FIFO_CNT_W = $clog2(RX_DEPTH + 1);

	// Item kinds
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// Register offsets
	localparam logic [2:0] REG_DATA = 3'd0;
	localparam logic [2:0] REG_IER  = 3'd1;
	localparam logic [2:0] REG_IIR  = 3'd2;
	localparam logic [2:0] REG_LCR  = 3'd3;
	localparam logic [2:0] REG_MCR  = 3'd4;
	localparam logic [2:0] REG_LSR  = 3'd5;
	localparam logic [2:0] REG_MSR  = 3'd6;
	localparam logic [2:0] REG_SCR  = 3'd7;

	// Attached device codes
	localparam logic [1:0] DEV_NONE  = 2'd0;
	localparam logic [1:0] DEV_BOARD = 2'd1;

	// Fixed register values and characters
	localparam int         LCR_DLAB_BIT = 7;
	localparam logic [7:0] LSR_TX_IDLE  = 8'h60;
	localparam logic [7:0] LSR_RX_READY = 8'h01;
	localparam logic [7:0] IIR_NONE     = 8'h01;
	localparam logic [7:0] MSR_VALUE    = 8'h00;
	localparam logic [7:0] CHAR_LF      = 8'h0A;
	localparam logic [7:0] CHAR_CR      = 8'h0D;

	// Status text loaded by a drive-board tick, first character at index 0
	localparam int STATUS_LEN = 3;
	localparam logic [STATUS_LEN-1:0][7:0] STATUS_TEXT = {8'h31, 8'h30, 8'h43};

	// FIFO commands from the register logic
	typedef struct packed {
		logic pop;
		logic load;
	} fifo_ctl_t;

	// FIFO status back to the register logic
	typedef struct packed {
		logic       not_empty;
		logic [7:0] head;
	} fifo_stat_t;

endpackage

`default_nettype wire

/* src/uartrf_rx_fifo.sv */
// Receive FIFO: byte store, read pointer and fill count.
`timescale 1ns / 1ps
`default_nettype none

module uartrf_rx_fifo
	import uartrf_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  fifo_ctl_t  ctl,
	output fifo_stat_t stat
);

	logic [7:0]            rx_store_q [RX_DEPTH];
	logic [FIFO_PTR_W-1:0] rd_pos_q;
	logic [FIFO_CNT_W-1:0] count_q;

	// Head entry and empty flag
	assign stat.not_empty = (count_q != '0);
	assign stat.head      = rx_store_q[rd_pos_q];

	// Store: status text goes to the first entries on a load
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < STATUS_LEN; i++) begin
				rx_store_q[i] <= STATUS_TEXT[i];
			end
		end
	end

	// Pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pos_q <= '0;
			count_q  <= '0;
		end else if (ctl.load) begin
			rd_pos_q <= '0;
			count_q  <= FIFO_CNT_W'(STATUS_LEN);
		end else if (ctl.pop && stat.not_empty) begin
			if (rd_pos_q == FIFO_PTR_W'(RX_DEPTH - 1)) begin
				rd_pos_q <= '0;
			end else begin
				rd_pos_q <= rd_pos_q + 1'b1;
			end
			count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	// Only the status text ever enters, so the count stays small
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(STATUS_LEN))
		else $error("rx fifo count above status length");

	// A load only lands in an empty FIFO
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> !stat.not_empty)
		else $error("rx fifo load while holding data");

	// A pop of a non-empty FIFO removes exactly one byte
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.pop && !ctl.load && stat.not_empty) |=> (count_q == $past(count_q) - 1'b1))
		else $error("rx fifo pop did not decrement count");
`endif

endmodule

`default_nettype wire

/* src/uart_register_file_with_rx_fifo_core.sv */
// Top level: 16550-style register file with receive FIFO and console transmit.
//
//  Channel  Dir  Signals                          Contents
//  s_axis   in   tvalid tready tdata[15:0]        mode, reg_index, write_data
//  m_axis   out  tvalid tready tdata[23:0] tuser  read_data, tx_byte, irq_pulse;
//                tlast                            tuser tx_valid, tlast tx_line_end
//  cfg      in   cfg_valid cfg_ready cfg_data[1:0] attached_device
//
// One item per cycle sustained while results are taken; each item passes the input
// register, then the result register. All item-driven register and FIFO updates happen
// in one pass through the decode logic of the input stage.
// The input stage advances whenever the result register is empty or being taken.
// Reset clears the valid flags, the architectural registers and the FIFO count; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module uart_register_file_with_rx_fifo_core
	import uartrf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,  // [1:0] mode, [4:2] reg_index, [12:5] write_data
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] read_data, [15:8] tx_byte, [16] irq_pulse
	output logic        m_axis_tuser,  // [0] tx_valid
	output logic        m_axis_tlast,  // tx_line_end
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_data        // [1:0] attached_device
);

	// Input stage
	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [2:0] idx_s1;
	logic [7:0] wdata_s1;

	// Result register
	logic       out_valid_q;
	logic [7:0] out_rd_q;
	logic [7:0] out_txb_q;
	logic       out_txv_q;
	logic       out_eol_q;
	logic       out_irq_q;

	// Architectural registers
	logic [1:0] dev_q;
	logic [7:0] lcr_q;
	logic [7:0] mcr_q;
	logic [7:0] scr_q;
	logic [7:0] ier_q;
	logic [7:0] dll_q;
	logic [7:0] dlm_q;

	// Decode results
	logic       advance;
	logic       fire;
	logic       dlab;
	logic [7:0] rd_d;
	logic [7:0] txb_d;
	logic       txv_d;
	logic       eol_d;
	logic       irq_d;
	logic       we_lcr, we_mcr, we_scr, we_ier, we_dll, we_dlm;

	fifo_ctl_t  fifo_ctl;
	fifo_stat_t fifo_stat;

	uartrf_rx_fifo u_rx_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fifo_ctl),
		.stat   (fifo_stat)
	);

	// Handshakes
	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;
	assign dlab          = lcr_q[LCR_DLAB_BIT];

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1  <= s_axis_tdata[1:0];
			idx_s1   <= s_axis_tdata[4:2];
			wdata_s1 <= s_axis_tdata[12:5];
		end
	end

	// Register decode for the item in the input stage
	always_comb begin
		rd_d          = '0;
		txb_d         = '0;
		txv_d         = 1'b0;
		eol_d         = 1'b0;
		irq_d         = 1'b0;
		we_lcr        = 1'b0;
		we_mcr        = 1'b0;
		we_scr        = 1'b0;
		we_ier        = 1'b0;
		we_dll        = 1'b0;
		we_dlm        = 1'b0;
		fifo_ctl.pop  = 1'b0;
		fifo_ctl.load = 1'b0;
		unique case (mode_s1)
			MODE_READ: begin
				unique case (idx_s1)
					REG_DATA: begin
						if (dlab) begin
							rd_d = dll_q;
						end else begin
							rd_d         = fifo_stat.not_empty ? fifo_stat.head : 8'h00;
							fifo_ctl.pop = fire;
						end
					end
					REG_IER: rd_d = dlab ? dlm_q : ier_q;
					REG_IIR: rd_d = IIR_NONE;
					REG_LCR: rd_d = lcr_q;
					REG_MCR: rd_d = mcr_q;
					REG_LSR: rd_d = LSR_TX_IDLE | (fifo_stat.not_empty ? LSR_RX_READY : 8'h00);
					REG_MSR: rd_d = MSR_VALUE;
					REG_SCR: rd_d = scr_q;
				endcase
			end
			MODE_WRITE: begin
				unique case (idx_s1)
					REG_DATA: begin
						if (dlab) begin
							we_dll = fire;
						end else if (dev_q == DEV_NONE) begin
							if (wdata_s1 == CHAR_LF) begin
								eol_d = 1'b1;
							end else if (wdata_s1 != CHAR_CR) begin
								txv_d = 1'b1;
								txb_d = wdata_s1;
							end
						end
					end
					REG_IER: begin
						we_dlm = fire && dlab;
						we_ier = fire && !dlab;
					end
					REG_LCR: we_lcr = fire;
					REG_MCR: we_mcr = fire;
					REG_SCR: we_scr = fire;
					REG_IIR, REG_LSR, REG_MSR: ;
				endcase
			end
			MODE_TICK: begin
				if (dev_q == DEV_BOARD) begin
					irq_d         = 1'b1;
					fifo_ctl.load = fire && !fifo_stat.not_empty;
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= DEV_NONE;
			lcr_q <= '0;
			mcr_q <= '0;
			scr_q <= '0;
			ier_q <= '0;
			dll_q <= '0;
			dlm_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) dev_q <= cfg_data;
			if (we_lcr) lcr_q <= wdata_s1;
			if (we_mcr) mcr_q <= wdata_s1;
			if (we_scr) scr_q <= wdata_s1;
			if (we_ier) ier_q <= wdata_s1;
			if (we_dll) dll_q <= wdata_s1;
			if (we_dlm) dlm_q <= wdata_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_rd_q  <= rd_d;
			out_txb_q <= txb_d;
			out_txv_q <= txv_d;
			out_eol_q <= eol_d;
			out_irq_q <= irq_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_irq_q, out_txb_q, out_rd_q};
	assign m_axis_tuser  = out_txv_q;
	assign m_axis_tlast  = out_eol_q;

`ifndef SYNTHESIS
	// Console output only comes from a write, so no read data alongside it
	a_tx_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser || m_axis_tlast)) |-> (m_axis_tdata[7:0] == 8'h00))
		else $error("console output with read data");

	// A newline marks line end without a transmitted byte
	a_eol_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (!m_axis_tuser && m_axis_tdata[15:8] == 8'h00))
		else $error("line end carries a byte");

	// A drive-board tick always leaves data in the FIFO
	a_tick_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && mode_s1 == MODE_TICK && dev_q == DEV_BOARD) |=> fifo_stat.not_empty)
		else $error("tick left rx fifo empty");
`endif

endmodule

`default_nettype wire

/* sim/tb_uart_register_file_with_rx_fifo_core.sv */
// Testbench for the UART register file core: random register traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_uart_register_file_with_rx_fifo_core;
	import uartrf_pkg::*;

	// Codes the package leaves unnamed
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] DEV_OTHER   = 2'd2;
	localparam logic [1:0] DEV_SPARE   = 2'd3;

	localparam int IDLE_MAX      = 19;
	localparam int HOLD_CYCLES   = 250;
	localparam int SETTLE_CYCLES = 4;
	localparam int TOTAL_ITEMS   = 1450;
	localparam int PHASE_ITEMS   = 180;

	// One result item, split into its fields
	typedef struct packed {
		logic [7:0] read_data;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       line_end;
		logic       irq;
	} uart_result_t;

	// Register and FIFO predictor with the queue of expected results
	class uart_reg_scoreboard;
		logic [1:0]   device;
		logic [7:0]   rx_data [RX_DEPTH];
		int unsigned  rx_head;
		int unsigned  rx_fill;
		logic [7:0]   lcr, mcr, scr, ier, div_lo, div_hi;
		uart_result_t expected_q [$];
		int unsigned  fail_count;

		function new();
			device = DEV_NONE;
			rx_head = 0;
			rx_fill = 0;
			lcr = 8'h00;
			mcr = 8'h00;
			scr = 8'h00;
			ier = 8'h00;
			div_lo = 8'h00;
			div_hi = 8'h00;
			fail_count = 0;
		endfunction

		function void apply_device(logic [1:0] value);
			device = value;
		endfunction

		// Apply one accepted item and queue the result it should give
		function void note_item(logic [1:0] kind, logic [2:0] idx, logic [7:0] wd);
			uart_result_t res;
			logic dlab;
			int i;
			res = '0;
			dlab = lcr[LCR_DLAB_BIT];
			case (kind)
			MODE_READ: begin
				case (idx)
				REG_DATA: begin
					if (dlab) begin
						res.read_data = div_lo;
					end else if (rx_fill != 0) begin
						res.read_data = rx_data[rx_head];
						rx_head = (rx_head + 1) % RX_DEPTH;
						rx_fill--;
					end
				end
				REG_IER: res.read_data = dlab ? div_hi : ier;
				REG_IIR: res.read_data = IIR_NONE;
				REG_LCR: res.read_data = lcr;
				REG_MCR: res.read_data = mcr;
				REG_LSR: res.read_data = LSR_TX_IDLE | ((rx_fill != 0) ? LSR_RX_READY : 8'h00);
				REG_MSR: res.read_data = MSR_VALUE;
				default: res.read_data = scr;
				endcase
			end
			MODE_WRITE: begin
				case (idx)
				REG_DATA: begin
					if (dlab) begin
						div_lo = wd;
					end else if (device == DEV_NONE) begin
						// LF marks line end, CR is dropped
						if (wd == CHAR_LF) begin
							res.line_end = 1'b1;
						end else if (wd != CHAR_CR) begin
							res.tx_valid = 1'b1;
							res.tx_byte = wd;
						end
					end
				end
				REG_IER: begin
					if (dlab) div_hi = wd;
					else ier = wd;
				end
				REG_LCR: lcr = wd;
				REG_MCR: mcr = wd;
				REG_SCR: scr = wd;
				default: ;
				endcase
			end
			MODE_TICK: begin
				// drive board: status text into an empty FIFO, irq regardless
				if (device == DEV_BOARD) begin
					if (rx_fill == 0) begin
						for (i = 0; i < STATUS_LEN; i++) rx_data[i] = STATUS_TEXT[i];
						rx_fill = STATUS_LEN;
						rx_head = 0;
					end
					res.irq = 1'b1;
				end
			end
			default: ;
			endcase
			expected_q.push_back(res);
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(uart_result_t got);
			uart_result_t exp;
			if (expected_q.size() == 0) begin
				$display("%0t ns: unexpected result %h, nothing expected", $time, got);
				fail_count++;
				return;
			end
			exp = expected_q.pop_front();
			if (got.read_data !== exp.read_data) begin
				$display("%0t ns: read_data expected %02h, got %02h",
					$time, exp.read_data, got.read_data);
				fail_count++;
			end
			if (got.tx_valid !== exp.tx_valid) begin
				$display("%0t ns: tx_valid expected %b, got %b", $time, exp.tx_valid, got.tx_valid);
				fail_count++;
			end
			if (got.tx_byte !== exp.tx_byte) begin
				$display("%0t ns: tx_byte expected %02h, got %02h", $time, exp.tx_byte, got.tx_byte);
				fail_count++;
			end
			if (got.line_end !== exp.line_end) begin
				$display("%0t ns: tx_line_end expected %b, got %b",
					$time, exp.line_end, got.line_end);
				fail_count++;
			end
			if (got.irq !== exp.irq) begin
				$display("%0t ns: irq_pulse expected %b, got %b", $time, exp.irq, got.irq);
				fail_count++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data = '0;

	uart_reg_scoreboard sb = new();

	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	bit          hold_req = 1'b0;
	int unsigned items_sent = 0;

	uart_register_file_with_rx_fifo_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watch all three handshakes at the clock edge
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			sb.apply_device(cfg_data);
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_item(s_axis_tdata[1:0], s_axis_tdata[4:2], s_axis_tdata[12:5]);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result('{read_data: m_axis_tdata[7:0], tx_valid: m_axis_tuser,
				tx_byte: m_axis_tdata[15:8], line_end: m_axis_tlast, irq: m_axis_tdata[16]});
	end

	// Result side: random stalls per item, plus one long hold on request
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				gap = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Offer one item; valid stays high when the next gap is zero
	task automatic send_item(input logic [1:0] kind, input logic [2:0] idx, input logic [7:0] wd);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, wd, idx, kind};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
	endtask

	// Stop offering and let every expected result come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		// let the last accepted item reach the queue first
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_device(input logic [1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Data byte biased toward the characters the console treats specially
	function automatic logic [7:0] console_byte();
		case ($urandom_range(0, 7))
		0: return CHAR_LF;
		1: return CHAR_CR;
		2: return 8'hFF;
		3: return 8'h00;
		default: return 8'($urandom);
		endcase
	endfunction

	// One random sequence: mostly well-formed register usage, some noise
	task automatic random_sequence();
		int n;
		logic [2:0] idx;
		logic [7:0] wd;
		case ($urandom_range(0, 9))
		0, 1, 2: begin
			// status tick then FIFO data and line status reads
			send_item(MODE_TICK, 3'($urandom), 8'($urandom));
			n = $urandom_range(0, 5);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0) send_item(MODE_READ, REG_LSR, 8'($urandom));
				else send_item(MODE_READ, REG_DATA, 8'($urandom));
			end
		end
		3, 4: begin
			// console output
			n = $urandom_range(1, 6);
			repeat (n) send_item(MODE_WRITE, REG_DATA, console_byte());
		end
		5, 6: begin
			// divisor latch access, then latch bit cleared again
			send_item(MODE_WRITE, REG_LCR, {1'b1, 7'($urandom)});
			send_item(MODE_WRITE, REG_DATA, 8'($urandom));
			send_item(MODE_WRITE, REG_IER, 8'($urandom));
			send_item(MODE_READ, REG_DATA, 8'($urandom));
			send_item(MODE_READ, REG_IER, 8'($urandom));
			send_item(MODE_WRITE, REG_LCR, {1'b0, 7'($urandom)});
		end
		7, 8: begin
			// write then read back a non-data register
			idx = 3'($urandom_range(1, 7));
			wd = 8'($urandom);
			if (idx == REG_LCR) wd[LCR_DLAB_BIT] = 1'b0;
			send_item(MODE_WRITE, idx, wd);
			send_item(MODE_READ, idx, 8'($urandom));
		end
		default: begin
			send_item(2'($urandom), 3'($urandom), 8'($urandom));
		end
		endcase
	endtask

	// Main sequence
	initial begin
		logic [1:0] phase_dev [8];
		int phase;
		int start;
		phase_dev = '{DEV_BOARD, DEV_NONE, DEV_SPARE, DEV_BOARD,
			DEV_OTHER, DEV_NONE, DEV_BOARD, DEV_NONE};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values, console characters, divisor latch, read-only offsets
		send_item(MODE_READ, REG_DATA, 8'h00);
		send_item(MODE_READ, REG_IER, 8'h00);
		send_item(MODE_READ, REG_IIR, 8'h00);
		send_item(MODE_READ, REG_LCR, 8'h00);
		send_item(MODE_READ, REG_MCR, 8'h00);
		send_item(MODE_READ, REG_LSR, 8'h00);
		send_item(MODE_READ, REG_MSR, 8'h00);
		send_item(MODE_READ, REG_SCR, 8'hFF);
		send_item(MODE_WRITE, REG_SCR, 8'hFF);
		send_item(MODE_WRITE, REG_DATA, 8'h41);
		send_item(MODE_WRITE, REG_DATA, CHAR_LF);
		send_item(MODE_WRITE, REG_DATA, CHAR_CR);
		send_item(MODE_WRITE, REG_DATA, 8'hFF);
		send_item(MODE_WRITE, REG_LCR, 8'h80);
		send_item(MODE_WRITE, REG_DATA, 8'hFF);
		send_item(MODE_WRITE, REG_IER, 8'hA5);
		send_item(MODE_READ, REG_DATA, 8'h00);
		send_item(MODE_READ, REG_IER, 8'h00);
		send_item(MODE_WRITE, REG_LCR, 8'h03);
		send_item(MODE_WRITE, REG_IIR, 8'hFF);
		send_item(MODE_WRITE, REG_LSR, 8'hFF);
		send_item(MODE_WRITE, REG_MSR, 8'hFF);
		send_item(MODE_UNUSED, REG_SCR, 8'hFF);
		send_item(MODE_TICK, REG_DATA, 8'h00);

		// Drive board: tick into an empty FIFO, tick with data waiting, pop past empty
		write_device(DEV_BOARD);
		send_item(MODE_TICK, REG_DATA, 8'h00);
		send_item(MODE_TICK, REG_DATA, 8'h00);
		send_item(MODE_READ, REG_LSR, 8'h00);
		repeat (4) send_item(MODE_READ, REG_DATA, 8'h00);
		send_item(MODE_WRITE, REG_DATA, 8'h55);

		// Other device: neither transmits nor injects status
		write_device(DEV_OTHER);
		send_item(MODE_TICK, REG_DATA, 8'h00);
		send_item(MODE_WRITE, REG_DATA, 8'h55);

		// Random phases over all device settings and idling modes
		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			write_device(phase_dev[phase % 8]);
			tx_idle_on = (phase % 3) != 2;
			rx_idle_on = (phase % 4) != 3;
			if (phase == 1) begin
				// receiver holds off while the sender keeps offering back to back
				tx_idle_on = 1'b0;
				hold_req = 1'b1;
			end
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS && items_sent < TOTAL_ITEMS)
				random_sequence();
			if (phase == 1) begin
				while (hold_req) @(posedge clk);
			end
			phase++;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
